// ===== hw/rtl/pre_pkg.sv =====
// shared types and constants of the partition refinement engine
// no dependencies; used by the split unit, the core, the checker and the bench
package pre_pkg;

  // default universe size
  localparam int MAX_ELEMENTS_DEF = 256;

  // fixed field widths
  localparam int IDX_W   = 16;
  localparam int COUNT_W = 9;

  // item modes carried on tuser
  localparam logic [1:0] MODE_ADD     = 2'd0;
  localparam logic [1:0] MODE_QUERY   = 2'd1;
  localparam logic [1:0] MODE_RESTART = 2'd2;

  // configuration register indexes
  localparam logic CFG_INDEX_BASE    = 1'b0;
  localparam logic CFG_ELEMENT_COUNT = 1'b1;

  // per-entry decision of the split unit
  typedef struct packed {
    logic split;      // entry moves to the other half of its block
    logic other_we;   // update the per-leader record
    logic leader_we;  // rewrite the entry's leader
  } split_ctl_t;

endpackage

// ===== hw/rtl/pre_ram.sv =====
// generic single-write, single-read memory with registered read data
// no dependencies
module pre_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hw/rtl/pre_split_unit.sv =====
// per-entry refinement decision: compares membership with the block leader's
// and picks the leader of the half that lacks the old leader; uses pre_pkg
module pre_split_unit #(
  parameter int LW = 8
) (
  input  logic                in_range,   // entry lies inside the live universe
  input  logic [LW-1:0]       idx,        // entry being walked
  input  logic [LW-1:0]       old_ldr,    // its current leader
  input  logic                mbit,       // entry membership
  input  logic [LW+1:0]       rec_rd,     // leader record {mbit, valid, new leader}
  output pre_pkg::split_ctl_t ctl,
  output logic [LW+1:0]       rec_wd,
  output logic [LW-1:0]       leader_wd
);

  logic          is_ldr;
  logic          rec_mbit;
  logic          rec_vld;
  logic [LW-1:0] rec_idx;

  assign is_ldr   = (old_ldr == idx);
  assign rec_mbit = rec_rd[LW+1];
  assign rec_vld  = rec_rd[LW];
  assign rec_idx  = rec_rd[LW-1:0];

  // a leader opens a fresh record; any other entry compares against it
  always_comb begin
    ctl.split     = in_range && !is_ldr && (mbit != rec_mbit);
    ctl.other_we  = in_range && (is_ldr || (ctl.split && !rec_vld));
    ctl.leader_we = ctl.split;
    if (is_ldr) begin
      rec_wd = {mbit, 1'b0, {LW{1'b0}}};
    end else begin
      rec_wd = {rec_mbit, 1'b1, idx};
    end
    leader_wd = rec_vld ? rec_idx : idx;
  end

endmodule

// ===== hw/rtl/partition_refinement_engine_core.sv =====
// add: no result unless the element is out of range (result next cycle)
// query: result registered from the leader table read in ST_QRY; restart: busy with a clearing pass
// refine (add with tlast): walks all MAX_ELEMENTS table entries, each through ST_RD1, ST_RD2
// and ST_EXE, result after the last entry; one item at a time
// reset (rst_n low, synchronous) starts a clearing pass over all MAX_ELEMENTS
// entries of the leader and membership memories before the first transfer
module partition_refinement_engine_core #(
  parameter int MAX_ELEMENTS = pre_pkg::MAX_ELEMENTS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  // input items
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // [15:0] element
  input  logic [1:0]  in_tuser,   // [1:0] mode
  input  logic        in_tlast,   // last
  // results
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // [15:0] leader, [16] changed, [17] error, rest zero
  // configuration writes
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [15:0] cfg_data
);

  localparam int LW = $clog2(MAX_ELEMENTS);
  localparam int OW = LW + 2;
  localparam logic [LW-1:0] LAST_IDX = LW'(MAX_ELEMENTS - 1);
  localparam logic [pre_pkg::IDX_W:0] MAX_W = (pre_pkg::IDX_W + 1)'(MAX_ELEMENTS);

  typedef enum logic [2:0] {
    ST_CLEAR, ST_IDLE, ST_QRY, ST_RD1, ST_RD2, ST_EXE
  } state_t;

  state_t                       st_r;
  logic [LW-1:0]                idx_r;
  logic [LW-1:0]                old_r;
  logic                         mbit_r;
  logic                         split_acc_r;
  logic                         err_r;
  logic                         out_valid_r;
  logic [15:0]                  out_leader_r;
  logic                         out_changed_r;
  logic                         out_error_r;
  logic [pre_pkg::IDX_W-1:0]    base_r;
  logic [pre_pkg::COUNT_W-1:0]  count_r;

  logic [pre_pkg::IDX_W-1:0]    off;
  logic                         ok;
  logic [LW-1:0]                inner;
  logic                         in_xfer;
  logic                         in_range;
  logic [LW-1:0]                ldr_rd;
  logic                         mem_rd;
  logic [OW-1:0]                rec_rd;
  logic [OW-1:0]                rec_wd;
  logic [LW-1:0]                leader_wd;
  pre_pkg::split_ctl_t          ctl;

  // configuration registers, always writable
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r  <= '0;
      count_r <= 9'd256;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        pre_pkg::CFG_INDEX_BASE:    base_r  <= cfg_data;
        pre_pkg::CFG_ELEMENT_COUNT: count_r <= cfg_data[pre_pkg::COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  // outer to inner index and range check
  assign off      = in_tdata - base_r;
  assign ok       = (off < {7'd0, count_r}) && ({1'b0, off} < MAX_W);
  assign inner    = off[LW-1:0];
  assign in_tready = (st_r == ST_IDLE) && !out_valid_r;
  assign in_xfer  = in_tvalid && in_tready;
  assign in_range = (16'(idx_r) < {7'd0, count_r});

  // leader table
  pre_ram #(.WIDTH(LW), .DEPTH(MAX_ELEMENTS)) u_leader_ram (
    .clk   (clk),
    .we    ((st_r == ST_CLEAR) || ((st_r == ST_EXE) && ctl.leader_we)),
    .waddr (idx_r),
    .wdata ((st_r == ST_CLEAR) ? '0 : leader_wd),
    .raddr ((st_r == ST_IDLE) ? inner : idx_r),
    .rdata (ldr_rd)
  );

  // membership bitmap, set by add transfers, cleared by the walk and the clearing pass
  pre_ram #(.WIDTH(1), .DEPTH(MAX_ELEMENTS)) u_member_ram (
    .clk   (clk),
    .we    ((st_r == ST_CLEAR) || (st_r == ST_EXE) ||
            (in_xfer && (in_tuser == pre_pkg::MODE_ADD) && ok)),
    .waddr ((st_r == ST_IDLE) ? inner : idx_r),
    .wdata (st_r == ST_IDLE),
    .raddr (idx_r),
    .rdata (mem_rd)
  );

  // per-leader record of the split half
  pre_ram #(.WIDTH(OW), .DEPTH(MAX_ELEMENTS)) u_other_ram (
    .clk   (clk),
    .we    ((st_r == ST_EXE) && ctl.other_we),
    .waddr (old_r),
    .wdata (rec_wd),
    .raddr (ldr_rd),
    .rdata (rec_rd)
  );

  pre_split_unit #(.LW(LW)) u_split (
    .in_range  (in_range),
    .idx       (idx_r),
    .old_ldr   (old_r),
    .mbit      (mbit_r),
    .rec_rd    (rec_rd),
    .ctl       (ctl),
    .rec_wd    (rec_wd),
    .leader_wd (leader_wd)
  );

  // sequencer and result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= ST_CLEAR;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
      split_acc_r <= 1'b0;
      err_r       <= 1'b0;
    end else begin
      if (out_valid_r && out_tready) begin
        out_valid_r <= 1'b0;
      end
      unique case (st_r)
        ST_CLEAR: begin
          idx_r <= idx_r + LW'(1);
          if (idx_r == LAST_IDX) begin
            st_r <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (in_xfer) begin
            err_r <= !ok;
            idx_r <= '0;
            priority if (in_tuser == pre_pkg::MODE_ADD) begin
              split_acc_r <= 1'b0;
              if (in_tlast) begin
                st_r <= ST_RD1;
              end else if (!ok) begin
                out_valid_r   <= 1'b1;
                out_leader_r  <= '0;
                out_changed_r <= 1'b0;
                out_error_r   <= 1'b1;
              end
            end else if (in_tuser == pre_pkg::MODE_QUERY) begin
              st_r <= ST_QRY;
            end else if (in_tuser == pre_pkg::MODE_RESTART) begin
              st_r <= ST_CLEAR;
            end else begin
              st_r <= ST_IDLE;
            end
          end
        end
        ST_QRY: begin
          out_valid_r   <= 1'b1;
          out_leader_r  <= err_r ? 16'd0 : (16'(ldr_rd) + base_r);
          out_changed_r <= 1'b0;
          out_error_r   <= err_r;
          st_r          <= ST_IDLE;
        end
        ST_RD1: begin
          st_r <= ST_RD2;
        end
        ST_RD2: begin
          old_r  <= ldr_rd;
          mbit_r <= mem_rd;
          st_r   <= ST_EXE;
        end
        ST_EXE: begin
          if (ctl.split) begin
            split_acc_r <= 1'b1;
          end
          idx_r <= idx_r + LW'(1);
          if (idx_r == LAST_IDX) begin
            out_valid_r   <= 1'b1;
            out_leader_r  <= '0;
            out_changed_r <= split_acc_r || ctl.split;
            out_error_r   <= err_r;
            st_r          <= ST_IDLE;
          end else begin
            st_r <= ST_RD1;
          end
        end
        default: st_r <= ST_IDLE;
      endcase
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {6'd0, out_error_r, out_changed_r, out_leader_r};

endmodule

// ===== hw/rtl/pre_checker.sv =====
// port-level checks of the partition refinement engine, bound to the top level
// depends on pre_pkg and partition_refinement_engine_core
module pre_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic [1:0]  in_tuser,
  input logic        in_tlast,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [23:0] out_tdata
);

  // a stalled result holds its payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> $stable(out_tdata))
    else $error("result changed while stalled");

  // no new item while a result waits
  a_busy_out: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !in_tready)
    else $error("input ready while result pending");

  // query, restart and refine keep the engine busy the next cycle
  a_busy_work: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready &&
    (in_tuser == pre_pkg::MODE_QUERY || in_tuser == pre_pkg::MODE_RESTART ||
     (in_tuser == pre_pkg::MODE_ADD && in_tlast)) |=> !in_tready)
    else $error("input ready right after a multi-cycle item");

  // error and change results carry no leader
  a_flag_leader: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tdata[16] || out_tdata[17]) |-> out_tdata[15:0] == 16'd0)
    else $error("leader set on a flag result");

endmodule

bind partition_refinement_engine_core pre_checker u_pre_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tuser   (in_tuser),
  .in_tlast   (in_tlast),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

// ===== bench/testbench.sv =====
// self-checking bench for partition_refinement_engine_core: directed table, then random
// splitting sets, queries and restarts checked against a behavioral partition predictor
// depends on hw/rtl/pre_pkg.sv and the core rtl
module testbench;

  localparam int MAX          = pre_pkg::MAX_ELEMENTS_DEF;
  localparam int ITEMS        = 1950;
  localparam int PHASE_ITEMS  = 150;
  localparam int SETTLE       = 3 * MAX + 32;
  localparam int STALL_LIMIT  = 10 * (3 * MAX + 64);
  localparam logic [1:0] MODE_ADD          = pre_pkg::MODE_ADD;
  localparam logic [1:0] MODE_QUERY        = pre_pkg::MODE_QUERY;
  localparam logic [1:0] MODE_RESTART      = pre_pkg::MODE_RESTART;
  localparam logic [1:0] MODE_IGNORED      = 2'd3;
  localparam logic       CFG_INDEX_BASE    = pre_pkg::CFG_INDEX_BASE;
  localparam logic       CFG_ELEMENT_COUNT = pre_pkg::CFG_ELEMENT_COUNT;

  // result fields, error in the top bit as on out_tdata[17:0]
  typedef struct packed {
    logic        error;
    logic        changed;
    logic [15:0] leader;
  } answer_t;

  typedef struct {
    logic [1:0]  mode;
    logic [15:0] elem;
    logic        last;
    bit          typed;
    answer_t     ans;
  } row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [15:0] in_tdata = '0;
  logic [1:0]  in_tuser = '0;
  logic        in_tlast = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [23:0] out_tdata;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic        cfg_index = 1'b0;
  logic [15:0] cfg_data = '0;

  // predictor state and configuration copy
  logic [7:0]  lead_of   [MAX];
  bit          in_set    [MAX];
  logic [8:0]  twin_lead [MAX];
  logic [15:0] cfg_base = '0;
  logic [8:0]  cfg_count = 9'd256;

  answer_t     pending_answers[$];
  row_t        plan_rows[$];
  bit          drive_typed = 1'b0;
  answer_t     typed_answer = '0;
  bit          calm = 1'b0;
  int          in_gap_pct = 0;
  int          out_gap_pct = 0;
  int          errors = 0;
  int          items_sent = 0;
  int          checked = 0;
  int          refinements = 0;
  int          settings = 0;
  int          idle_run = 0;

  partition_refinement_engine_core dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always #4 clk = ~clk;

  function automatic int live_size();
    return (cfg_count < MAX) ? int'(cfg_count) : MAX;
  endfunction

  // split every block into its part inside the set and its part outside
  task refine_blocks(output bit split);
    int n;
    int i;
    logic [7:0] old;
    n = live_size();
    split = 1'b0;
    for (i = 0; i < n; i++) begin
      old = lead_of[i];
      // reaching a leader opens a fresh record for its block
      if (old == i) twin_lead[i] = '0;
      if (in_set[i] != in_set[old]) begin
        if (twin_lead[old] == 0) twin_lead[old] = 9'(i + 1);
        lead_of[i] = 8'(twin_lead[old] - 9'd1);
        split = 1'b1;
      end
    end
    for (i = 0; i < MAX; i++) in_set[i] = 1'b0;
  endtask

  // one accepted item against the partition, with the answer it causes
  task partition_step(input logic [1:0] mode, input logic [15:0] elem, input logic last,
                      output bit has, output answer_t ans);
    logic [15:0] off;
    bit ok;
    bit split;
    int i;
    off = elem - cfg_base;
    ok = off < live_size();
    ans = '0;
    ans.error = !ok;
    has = 1'b0;
    case (mode)
      MODE_ADD: begin
        if (ok) in_set[off] = 1'b1;
        if (!last) begin
          has = !ok;
        end else begin
          refine_blocks(split);
          ans.changed = split;
          has = 1'b1;
          refinements++;
        end
      end
      MODE_QUERY: begin
        if (ok) ans.leader = lead_of[off] + cfg_base;
        has = 1'b1;
      end
      MODE_RESTART: begin
        for (i = 0; i < MAX; i++) begin
          lead_of[i] = '0;
          in_set[i] = 1'b0;
        end
      end
      default: ;
    endcase
  endtask

  // track transfers, predict, compare and watch for a hang
  always @(posedge clk) begin : scoreboard
    bit moved;
    bit has;
    answer_t calc;
    answer_t got;
    answer_t want;
    moved = 1'b0;
    if (rst_n) begin
      if (cfg_valid && cfg_ready) begin
        moved = 1'b1;
        if (cfg_index == CFG_INDEX_BASE) cfg_base = cfg_data;
        else cfg_count = cfg_data[8:0];
      end
      if (in_tvalid && in_tready) begin
        moved = 1'b1;
        partition_step(in_tuser, in_tdata, in_tlast, has, calc);
        if (has) pending_answers.insert(pending_answers.size(),
                                        drive_typed ? typed_answer : calc);
      end
      if (out_tvalid && out_tready) begin
        moved = 1'b1;
        got = out_tdata[17:0];
        checked++;
        if (pending_answers.size() == 0) begin
          $error("unexpected result: leader %0d changed %0b error %0b",
                 got.leader, got.changed, got.error);
          errors++;
        end else begin
          want = pending_answers.pop_front();
          if (got.leader !== want.leader) begin
            $error("leader: expected %0d, got %0d", want.leader, got.leader);
            errors++;
          end
          if (got.changed !== want.changed) begin
            $error("changed: expected %0b, got %0b", want.changed, got.changed);
            errors++;
          end
          if (got.error !== want.error) begin
            $error("error: expected %0b, got %0b", want.error, got.error);
            errors++;
          end
        end
      end
      idle_run = moved ? 0 : idle_run + 1;
      if (idle_run >= STALL_LIMIT) begin
        $display("timeout after %0d cycles without a transfer", idle_run);
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  // result side back-pressure in bursts
  initial begin : result_stalls
    forever begin
      @(negedge clk);
      if (!calm && $urandom_range(0, 99) < out_gap_pct) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 9)) @(negedge clk);
      end
      out_tready <= 1'b1;
    end
  end

  // one input transfer, with an optional gap in front
  task send_item(input logic [1:0] mode, input logic [15:0] elem, input logic last,
                 input bit typed, input answer_t ans);
    int gap;
    if (!calm && $urandom_range(0, 99) < in_gap_pct) begin
      in_tvalid <= 1'b0;
      gap = $urandom_range(1, 9);
      repeat (gap) @(negedge clk);
    end
    in_tvalid    <= 1'b1;
    in_tuser     <= mode;
    in_tdata     <= elem;
    in_tlast     <= last;
    drive_typed  <= typed;
    typed_answer <= ans;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    @(negedge clk);
    if (mode != MODE_IGNORED) items_sent++;
    if (items_sent >= ITEMS - PHASE_ITEMS) calm = 1'b1;
  endtask

  task write_reg(input logic idx, input logic [15:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
  endtask

  // drain all answers, then let any walk or restart finish
  task settle();
    while (pending_answers.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    @(negedge clk);
  endtask

  task plan(input logic [1:0] mode, input logic [15:0] elem, input logic last, input bit typed,
            input logic err, input logic chg, input logic [15:0] ldr);
    row_t r;
    r.mode = mode;
    r.elem = elem;
    r.last = last;
    r.typed = typed;
    r.ans.error = err;
    r.ans.changed = chg;
    r.ans.leader = ldr;
    plan_rows.insert(plan_rows.size(), r);
  endtask

  function automatic logic [15:0] outer_of(int inner);
    return 16'(inner + cfg_base);
  endfunction

  function automatic logic [15:0] in_range(int win);
    int n;
    n = live_size();
    if ($urandom_range(0, 1)) return outer_of($urandom_range(0, n - 1));
    return outer_of((win + $urandom_range(0, 15)) % n);
  endfunction

  function automatic logic [15:0] out_of_range();
    return outer_of($urandom_range(live_size(), 65535));
  endfunction

  // register setting for a phase: extremes first, then random
  task reconfigure(input int phase);
    logic [15:0] base;
    logic [15:0] count;
    in_tvalid <= 1'b0;
    settle();
    case (phase)
      0:       begin base = 16'd0;     count = 16'd256; end
      1:       begin base = 16'd65279; count = 16'd1;   end
      2:       begin base = 16'd65279; count = 16'd256; end
      3:       begin base = 16'd0;     count = 16'd1;   end
      4:       begin base = 16'd4660;  count = 16'd2;   end
      default: begin
        base = 16'($urandom_range(0, 65279));
        case ($urandom_range(0, 2))
          0:       count = 16'($urandom_range(1, 256));
          1:       count = 16'($urandom_range(1, 16));
          default: count = 16'd256;
        endcase
      end
    endcase
    if ($urandom_range(0, 1)) begin
      write_reg(CFG_INDEX_BASE, base);
      write_reg(CFG_ELEMENT_COUNT, count);
    end else begin
      write_reg(CFG_ELEMENT_COUNT, count);
      write_reg(CFG_INDEX_BASE, base);
    end
    cfg_valid <= 1'b0;
    settings++;
    case ($urandom_range(0, 2))
      0:       in_gap_pct = 0;
      1:       in_gap_pct = 15;
      default: in_gap_pct = 40;
    endcase
    case ($urandom_range(0, 2))
      0:       out_gap_pct = 0;
      1:       out_gap_pct = 15;
      default: out_gap_pct = 40;
    endcase
  endtask

  initial begin : stimulus
    int i;
    int kind;
    int n;
    int k;
    int win;
    int phase;
    int next_phase_at;
    logic [15:0] elem;
    for (i = 0; i < MAX; i++) begin
      lead_of[i] = '0;
      in_set[i] = 1'b0;
      twin_lead[i] = '0;
    end
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed: one block after reset, bounds, empty and duplicate sets,
    // a set equal to a block, out-of-range last, ignored mode, restart
    plan(MODE_QUERY,   16'd0,     1'b0, 1'b1, 1'b0, 1'b0, 16'd0);
    plan(MODE_QUERY,   16'd255,   1'b0, 1'b1, 1'b0, 1'b0, 16'd0);
    plan(MODE_QUERY,   16'd256,   1'b0, 1'b1, 1'b1, 1'b0, 16'd0);
    plan(MODE_QUERY,   16'hFFFF,  1'b0, 1'b1, 1'b1, 1'b0, 16'd0);
    plan(MODE_ADD,     16'hFFFF,  1'b0, 1'b1, 1'b1, 1'b0, 16'd0);
    plan(MODE_ADD,     16'hFFFF,  1'b1, 1'b1, 1'b1, 1'b0, 16'd0);
    plan(MODE_ADD,     16'd5,     1'b0, 1'b0, 1'b0, 1'b0, 16'd0);
    plan(MODE_ADD,     16'd3,     1'b0, 1'b0, 1'b0, 1'b0, 16'd0);
    plan(MODE_ADD,     16'd5,     1'b0, 1'b0, 1'b0, 1'b0, 16'd0);
    plan(MODE_ADD,     16'd200,   1'b1, 1'b1, 1'b0, 1'b1, 16'd0);
    plan(MODE_QUERY,   16'd5,     1'b0, 1'b1, 1'b0, 1'b0, 16'd3);
    plan(MODE_QUERY,   16'd200,   1'b0, 1'b1, 1'b0, 1'b0, 16'd3);
    plan(MODE_QUERY,   16'd4,     1'b0, 1'b1, 1'b0, 1'b0, 16'd0);
    plan(MODE_ADD,     16'd200,   1'b0, 1'b0, 1'b0, 1'b0, 16'd0);
    plan(MODE_ADD,     16'd3,     1'b0, 1'b0, 1'b0, 1'b0, 16'd0);
    plan(MODE_ADD,     16'd5,     1'b1, 1'b1, 1'b0, 1'b0, 16'd0);
    plan(MODE_ADD,     16'd255,   1'b0, 1'b0, 1'b0, 1'b0, 16'd0);
    plan(MODE_ADD,     16'hFFFF,  1'b1, 1'b1, 1'b1, 1'b1, 16'd0);
    plan(MODE_QUERY,   16'd255,   1'b0, 1'b1, 1'b0, 1'b0, 16'd255);
    plan(MODE_IGNORED, 16'hFFFF,  1'b1, 1'b0, 1'b0, 1'b0, 16'd0);
    plan(MODE_RESTART, 16'hFFFF,  1'b1, 1'b0, 1'b0, 1'b0, 16'd0);
    plan(MODE_QUERY,   16'd255,   1'b0, 1'b1, 1'b0, 1'b0, 16'd0);
    plan(MODE_ADD,     16'd0,     1'b1, 1'b1, 1'b0, 1'b1, 16'd0);
    plan(MODE_QUERY,   16'd1,     1'b0, 1'b1, 1'b0, 1'b0, 16'd1);
    plan(MODE_QUERY,   16'd0,     1'b0, 1'b1, 1'b0, 1'b0, 16'd0);
    foreach (plan_rows[i])
      send_item(plan_rows[i].mode, plan_rows[i].elem, plan_rows[i].last,
                plan_rows[i].typed, plan_rows[i].ans);

    // random: mostly splitting sets followed by queries, some noise
    phase = 0;
    next_phase_at = items_sent;
    while (items_sent < ITEMS) begin
      if (items_sent >= next_phase_at) begin
        reconfigure(phase);
        phase++;
        next_phase_at = items_sent + PHASE_ITEMS;
      end
      kind = $urandom_range(0, 99);
      win = $urandom_range(0, live_size() - 1);
      if (kind < 55) begin
        n = $urandom_range(1, 6);
        for (k = 0; k < n; k++) begin
          elem = ($urandom_range(0, 9) == 0) ? out_of_range() : in_range(win);
          send_item(MODE_ADD, elem, k == n - 1, 1'b0, '0);
        end
        n = $urandom_range(1, 4);
        for (k = 0; k < n; k++)
          send_item(MODE_QUERY, in_range(win), 1'($urandom_range(0, 1)), 1'b0, '0);
      end else if (kind < 75) begin
        n = $urandom_range(1, 4);
        for (k = 0; k < n; k++) begin
          elem = ($urandom_range(0, 4) == 0) ? 16'($urandom_range(0, 65535)) : in_range(win);
          send_item(MODE_QUERY, elem, 1'($urandom_range(0, 1)), 1'b0, '0);
        end
      end else if (kind < 83) begin
        send_item(2'($urandom_range(0, 3)), 16'($urandom_range(0, 65535)),
                  1'($urandom_range(0, 1)), 1'b0, '0);
      end else if (kind < 87) begin
        send_item(MODE_RESTART, 16'($urandom_range(0, 65535)), 1'($urandom_range(0, 1)),
                  1'b0, '0);
      end else begin
        // set left open, possibly across a register change
        n = $urandom_range(1, 3);
        for (k = 0; k < n; k++) send_item(MODE_ADD, in_range(win), 1'b0, 1'b0, '0);
      end
    end

    in_tvalid <= 1'b0;
    settle();
    $display("covered %0d items, %0d results checked, %0d refinements", items_sent, checked,
             refinements);
    $display("over %0d register settings, %0d mismatches", settings, errors);
    if (errors == 0 && pending_answers.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
